// ===== rtl/core/hpt_pkg.sv =====
// Shared constants and types for the homogeneous point transform unit.
`default_nettype none

package hpt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 64;
  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 4;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int MAG_W       = SUM_W - 1;
  localparam int REM_W       = MAG_W + 1;
  localparam int NUM_W       = MAG_W + FRAC_BITS;
  localparam int CMP_W       = MAG_W + DATA_W;
  localparam int Q_W         = DATA_W;
  localparam int DIV_BITS    = 2;
  localparam int DIV_STAGES  = Q_W / DIV_BITS;
  localparam int NUM_LANES   = 3;

  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (DATA_W + FRAC_BITS);

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic FUNC_POINT  = 1'b0;
  localparam logic FUNC_VECTOR = 1'b1;

  typedef logic signed [DATA_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [Q_W-1:0]   nlo;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic             big;
  } lane_t;

  typedef struct packed {
    logic             point;
    logic             inf;
    logic [MAG_W-1:0] den;
    coord_t           dx;
    coord_t           dy;
    coord_t           dz;
    logic             dovf;
  } ctx_t;

  function automatic logic [CFG_W-1:0] mat_reset(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_W-1:0] v;
    v = '0;
    case (idx)
      CFG_IDX_W'(0): v = ONE_LO;
      CFG_IDX_W'(2): v = ONE_HI;
      CFG_IDX_W'(5): v = ONE_LO;
      CFG_IDX_W'(7): v = ONE_HI;
      default:       v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hpt_row.sv =====
// One matrix row: three registered products, then a registered row sum.
`default_nettype none

module hpt_row (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [hpt_pkg::CFG_W-1:0]    left,
  input  wire logic [hpt_pkg::CFG_W-1:0]    right,
  input  wire logic                         with_trans,
  input  wire hpt_pkg::coord_t              x,
  input  wire hpt_pkg::coord_t              y,
  input  wire hpt_pkg::coord_t              z,
  output hpt_pkg::sum_t                     sum_r
);
  import hpt_pkg::*;

  coord_t e0, e1, e2, e3;
  logic signed [PROD_W-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  sum_t t_nxt, t_r, sum_nxt;

  assign e0 = left[DATA_W-1:0];
  assign e1 = left[CFG_W-1:DATA_W];
  assign e2 = right[DATA_W-1:0];
  assign e3 = right[CFG_W-1:DATA_W];

  assign p0_nxt = e0 * x;
  assign p1_nxt = e1 * y;
  assign p2_nxt = e2 * z;
  assign t_nxt  = with_trans ? (SUM_W'(e3) <<< FRAC_BITS) : '0;

  assign sum_nxt = SUM_W'(p0_r) + SUM_W'(p1_r) + SUM_W'(p2_r) + t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      t_r   <= t_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hpt_div_step.sv =====
// DIV_BITS restoring division steps on one lane: quotient bits come out MSB first.
`default_nettype none

module hpt_div_step (
  input  wire hpt_pkg::lane_t                lin,
  input  wire logic [hpt_pkg::MAG_W-1:0]     den,
  output hpt_pkg::lane_t                     lout
);
  import hpt_pkg::*;

  lane_t            l;
  logic [REM_W-1:0] trial;
  logic             ge;

  always_comb begin
    l = lin;
    trial = '0;
    ge = 1'b0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {l.rem, l.nlo[Q_W-1]};
      ge    = trial >= {1'b0, den};
      l.rem = ge ? MAG_W'(trial - {1'b0, den}) : trial[MAG_W-1:0];
      l.nlo = {l.nlo[Q_W-2:0], 1'b0};
      l.q   = {l.q[Q_W-2:0], ge};
    end
    lout = l;
  end

endmodule

`default_nettype wire

// ===== rtl/core/homogeneous_point_transform_unit.sv =====
// Top level: matrix registers, product/sum rows, divide pipeline and output stage.
// An accepted input beat passes through the products, row sums, setup,
// 16 two-bit divide stages and the output register, in that order.
// Throughput: one beat per cycle; a stall on the output freezes the whole pipe.
// Reset (synchronous, rst_n low) empties the pipe and loads the identity matrix.
`default_nettype none

module homogeneous_point_transform_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [hpt_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [hpt_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_func,
  input  wire hpt_pkg::coord_t                   in_x,
  input  wire hpt_pkg::coord_t                   in_y,
  input  wire hpt_pkg::coord_t                   in_z,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output hpt_pkg::coord_t                        out_x,
  output hpt_pkg::coord_t                        out_y,
  output hpt_pkg::coord_t                        out_z,
  output logic                                   out_at_infinity,
  output logic                                   out_overflow
);
  import hpt_pkg::*;

  localparam int NVLD = DIV_STAGES + 3;

  logic [CFG_W-1:0] mat_r [NUM_REGS];
  logic             en;
  logic [NVLD-1:0]  vld_r;
  logic             f1_r, f2_r;
  sum_t             sum [4];

  lane_t lane_r   [DIV_STAGES+1][NUM_LANES];
  lane_t lane_nxt [DIV_STAGES+1][NUM_LANES];
  ctx_t  ctx_r    [DIV_STAGES+1];
  ctx_t  ctx_nxt;

  coord_t ox_nxt, oy_nxt, oz_nxt;
  logic   inf_nxt, ovf_nxt;
  coord_t ox_r, oy_r, oz_r;
  logic   inf_r, ovf_r, ovalid_r;

  assign en       = !(ovalid_r && out_stall);
  assign in_stall = !en;

  // Matrix registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) mat_r[i] <= mat_reset(CFG_IDX_W'(i));
    end else if (cfg_we && (cfg_idx < CFG_IDX_W'(NUM_REGS))) begin
      mat_r[cfg_idx[$clog2(NUM_REGS)-1:0]] <= cfg_wdata;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    hpt_row u_row (
      .clk        (clk),
      .en         (en),
      .left       (mat_r[2*r]),
      .right      (mat_r[2*r+1]),
      .with_trans (in_func == FUNC_POINT),
      .x          (in_x),
      .y          (in_y),
      .z          (in_z),
      .sum_r      (sum[r])
    );
  end

  // Setup stage: magnitudes, signs, overflow precheck, direction-mode results.
  logic             wneg;
  logic [MAG_W-1:0] wmag;
  logic             sneg [NUM_LANES];
  logic [MAG_W-1:0] smag [NUM_LANES];
  logic [NUM_W-1:0] num  [NUM_LANES];
  coord_t           dval [NUM_LANES];
  logic             dov  [NUM_LANES];
  sum_t             sh   [NUM_LANES];

  always_comb begin
    wneg = sum[3][SUM_W-1];
    wmag = wneg ? MAG_W'(-sum[3]) : MAG_W'(sum[3]);
    for (int l = 0; l < NUM_LANES; l++) begin
      sneg[l] = sum[l][SUM_W-1];
      smag[l] = sneg[l] ? MAG_W'(-sum[l]) : MAG_W'(sum[l]);
      num[l]  = {smag[l], {FRAC_BITS{1'b0}}};
      lane_nxt[0][l].rem = MAG_W'(num[l] >> Q_W);
      lane_nxt[0][l].nlo = num[l][Q_W-1:0];
      lane_nxt[0][l].q   = '0;
      lane_nxt[0][l].neg = sneg[l] ^ wneg;
      lane_nxt[0][l].big = CMP_W'(smag[l]) >= (CMP_W'(wmag) << (Q_W - FRAC_BITS));
      sh[l] = sum[l] >>> FRAC_BITS;
      if (sh[l] > SUM_W'(signed'(SAT_POS))) begin
        dval[l] = SAT_POS;
        dov[l]  = 1'b1;
      end else if (sh[l] < SUM_W'(signed'(SAT_NEG))) begin
        dval[l] = SAT_NEG;
        dov[l]  = 1'b1;
      end else begin
        dval[l] = sh[l][DATA_W-1:0];
        dov[l]  = 1'b0;
      end
    end
    ctx_nxt.point = (f2_r == FUNC_POINT);
    ctx_nxt.inf   = (f2_r == FUNC_POINT) && (sum[3] == '0);
    ctx_nxt.den   = wmag;
    ctx_nxt.dx    = dval[0];
    ctx_nxt.dy    = dval[1];
    ctx_nxt.dz    = dval[2];
    ctx_nxt.dovf  = dov[0] | dov[1] | dov[2];
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      hpt_div_step u_step (
        .lin  (lane_r[s-1][l]),
        .den  (ctx_r[s-1].den),
        .lout (lane_nxt[s][l])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= in_func;
      f2_r <= f1_r;
      ctx_r[0] <= ctx_nxt;
      for (int l = 0; l < NUM_LANES; l++) lane_r[0][l] <= lane_nxt[0][l];
      for (int s = 1; s <= DIV_STAGES; s++) begin
        ctx_r[s] <= ctx_r[s-1];
        for (int l = 0; l < NUM_LANES; l++) lane_r[s][l] <= lane_nxt[s][l];
      end
    end
  end

  // Final sign and saturation of the quotients.
  coord_t qv  [NUM_LANES];
  logic   qov [NUM_LANES];
  lane_t  fl;

  always_comb begin
    fl = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      fl = lane_r[DIV_STAGES][l];
      if (!fl.neg) begin
        qov[l] = fl.big || fl.q[Q_W-1];
        qv[l]  = qov[l] ? SAT_POS : fl.q;
      end else begin
        qov[l] = fl.big || (fl.q > SAT_NEG);
        qv[l]  = qov[l] ? SAT_NEG : -fl.q;
      end
    end
    if (!ctx_r[DIV_STAGES].point) begin
      ox_nxt  = ctx_r[DIV_STAGES].dx;
      oy_nxt  = ctx_r[DIV_STAGES].dy;
      oz_nxt  = ctx_r[DIV_STAGES].dz;
      inf_nxt = 1'b0;
      ovf_nxt = ctx_r[DIV_STAGES].dovf;
    end else if (ctx_r[DIV_STAGES].inf) begin
      ox_nxt  = SAT_POS;
      oy_nxt  = SAT_POS;
      oz_nxt  = SAT_POS;
      inf_nxt = 1'b1;
      ovf_nxt = 1'b0;
    end else begin
      ox_nxt  = qv[0];
      oy_nxt  = qv[1];
      oz_nxt  = qv[2];
      inf_nxt = 1'b0;
      ovf_nxt = qov[0] | qov[1] | qov[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      oz_r  <= oz_nxt;
      inf_r <= inf_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      ovalid_r <= 1'b0;
    end else if (en) begin
      vld_r    <= {vld_r[NVLD-2:0], in_valid};
      ovalid_r <= vld_r[NVLD-1];
    end
  end

  assign out_valid       = ovalid_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_z           = oz_r;
  assign out_at_infinity = inf_r;
  assign out_overflow    = ovf_r;

endmodule

`default_nettype wire

// ===== rtl/core/hpt_checker.sv =====
// Port-level checks for the transform unit, bound to the top level.
`default_nettype none

module hpt_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire hpt_pkg::coord_t      out_x,
  input wire hpt_pkg::coord_t      out_y,
  input wire hpt_pkg::coord_t      out_z,
  input wire logic                 out_at_infinity,
  input wire logic                 out_overflow
);
  import hpt_pkg::*;

  // A stalled output beat holds its coordinates.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z))
    else $error("stalled output beat changed");

  // A point at infinity reports saturated coordinates and no overflow.
  a_inf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_infinity |-> out_x == SAT_POS && out_y == SAT_POS
      && out_z == SAT_POS && !out_overflow)
    else $error("infinity beat has wrong payload");

  // Overflow means some coordinate sits at a rail.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_x == SAT_POS || out_x == SAT_NEG
      || out_y == SAT_POS || out_y == SAT_NEG || out_z == SAT_POS || out_z == SAT_NEG)
    else $error("overflow without a saturated coordinate");

  // With no pending output beat the input side never stalls.
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind homogeneous_point_transform_unit hpt_checker u_hpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_x           (out_x),
  .out_y           (out_y),
  .out_z           (out_z),
  .out_at_infinity (out_at_infinity),
  .out_overflow    (out_overflow)
);

`default_nettype wire

// ===== dv/homogeneous_point_transform_unit_tb.sv =====
// Self-checking testbench for the homogeneous point transform unit.
`default_nettype none

module homogeneous_point_transform_unit_tb;
  import hpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int PIPE_DRAIN = 40;
  localparam int HOLD_LEN   = 150;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_LEN  = 60;

  typedef enum int {PRE_NONE, PRE_IDENTITY, PRE_W_ZERO, PRE_ALL_MAX, PRE_ALL_MIN} preset_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   inf;
    logic   ovf;
  } point_res_t;

  typedef struct {
    preset_t preset;
    logic    func;
    coord_t  x;
    coord_t  y;
    coord_t  z;
    bit      typed;
    coord_t  ex;
    coord_t  ey;
    coord_t  ez;
    logic    einf;
    logic    eovf;
  } dir_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            in_func = FUNC_POINT;
  coord_t          in_x = '0;
  coord_t          in_y = '0;
  coord_t          in_z = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  coord_t          out_x;
  coord_t          out_y;
  coord_t          out_z;
  logic            out_at_infinity;
  logic            out_overflow;

  logic [CFG_W-1:0] matrix [NUM_REGS];
  point_res_t       pending_points [$];
  int unsigned      mismatches = 0;
  int unsigned      beats_in = 0;
  int unsigned      beats_out = 0;
  int unsigned      inf_seen = 0;
  int unsigned      ovf_seen = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      hold_req = 0;
  int unsigned      hold_seen = 0;
  int unsigned      hold_left = 0;
  int unsigned      stall_left = 0;
  bit               no_gaps = 0;

  homogeneous_point_transform_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_at_infinity(out_at_infinity), .out_overflow(out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic coord_t mat_elem(input int row, input int col);
    logic [CFG_W-1:0] r;
    r = matrix[row * 2 + col / 2];
    return (col % 2) ? coord_t'(r[63:32]) : coord_t'(r[31:0]);
  endfunction

  function automatic logic signed [127:0] row_dot(input int row, input coord_t v [3],
                                                  input bit with_trans);
    logic signed [127:0] acc;
    logic signed [127:0] a;
    logic signed [127:0] b;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      a = mat_elem(row, c);
      b = v[c];
      acc += a * b;
    end
    if (with_trans) begin
      a = mat_elem(row, 3);
      acc += a <<< FRAC_BITS;
    end
    return acc;
  endfunction

  function automatic coord_t clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sh7FFFFFFF) begin
      ovf = 1'b1;
      return SAT_POS;
    end
    if (v < -128'sh80000000) begin
      ovf = 1'b1;
      return SAT_NEG;
    end
    return coord_t'(v[31:0]);
  endfunction

  function automatic point_res_t transform_point(input logic func, input coord_t x,
                                                 input coord_t y, input coord_t z);
    point_res_t r;
    coord_t v [3];
    coord_t o [3];
    logic signed [127:0] w;
    logic signed [127:0] s;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    r.inf = 1'b0;
    r.ovf = 1'b0;
    if (func == FUNC_POINT) begin
      w = row_dot(3, v, 1);
      for (int i = 0; i < 3; i++) begin
        if (w == 0) begin
          o[i] = SAT_POS;
        end else begin
          // Signed division truncates toward zero, as the divider does on magnitudes.
          s = row_dot(i, v, 1) <<< FRAC_BITS;
          o[i] = clamp32(s / w, r.ovf);
        end
      end
      r.inf = (w == 0);
    end else begin
      for (int i = 0; i < 3; i++) o[i] = clamp32(row_dot(i, v, 0) >>> FRAC_BITS, r.ovf);
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ERROR %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  task automatic write_reg(input int idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_IDX_W'(idx);
    cfg_wdata <= data;
    @(posedge clk);
    if (idx < NUM_REGS) matrix[idx] = data;
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic load_preset(input preset_t p);
    logic [CFG_W-1:0] d;
    wait_drained();
    for (int i = 0; i < NUM_REGS; i++) begin
      case (p)
        PRE_ALL_MAX: d = {2{SAT_POS}};
        PRE_ALL_MIN: d = {2{SAT_NEG}};
        default: begin
          d = (i == 0 || i == 5) ? ONE_LO : (i == 2 || i == 7) ? ONE_HI : '0;
          if (p == PRE_W_ZERO && i >= 6) d = '0;
        end
      endcase
      write_reg(i, d);
    end
    // Indexes past the last register must be dropped by the block.
    write_reg(NUM_REGS + $urandom_range(0, 7), {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // Holds the beat until accepted, then either keeps valid up or opens a gap.
  task automatic send_point(input logic func, input coord_t x, input coord_t y,
                            input coord_t z, input bit typed, input point_res_t want);
    int unsigned gap;
    in_valid <= 1'b1;
    in_func <= func;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_points.push_back(typed ? want : transform_point(func, x, y, z));
    beats_in++;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0:             gap = $urandom_range(10, 30);
        1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        default:       gap = 0;
      endcase
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
      2, 3, 4: return coord_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_elem(input int kind);
    case (kind)
      0:       return $urandom;
      3:       return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
      default: return $urandom_range(0, 3) == 0 ? 32'h0
                      : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  always @(posedge clk) begin
    point_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (out_at_infinity) inf_seen++;
      if (out_overflow) ovf_seen++;
      if (pending_points.size() == 0) begin
        report_mismatch("result beat with nothing expected", out_x, 32'h0);
      end else begin
        e = pending_points.pop_front();
        if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
        if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
        if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
        if (out_at_infinity !== e.inf)
          report_mismatch("at_infinity", 32'(out_at_infinity), 32'(e.inf));
        if (out_overflow !== e.ovf)
          report_mismatch("overflow", 32'(out_overflow), 32'(e.ovf));
      end
    end
  end

  // Receiver back-pressure: mostly short stalls, some long ones, plus requested hold-offs.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) < 7) begin
      out_stall <= 1'b0;
    end else begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  dir_row_t dir_table [] = '{
    '{PRE_NONE, FUNC_POINT, 32'sh00010000, 32'sh00020000, -32'sh00030000,
      1, 32'sh00010000, 32'sh00020000, -32'sh00030000, 0, 0},
    '{PRE_NONE, FUNC_POINT, SAT_POS, SAT_NEG, 32'sh0, 1, SAT_POS, SAT_NEG, 32'sh0, 0, 0},
    '{PRE_NONE, FUNC_POINT, 32'sh0, 32'sh0, 32'sh0, 1, 32'sh0, 32'sh0, 32'sh0, 0, 0},
    '{PRE_NONE, FUNC_VECTOR, SAT_NEG, 32'sh1, SAT_POS, 1, SAT_NEG, 32'sh1, SAT_POS, 0, 0},
    '{PRE_NONE, FUNC_VECTOR, -32'sh1, 32'sh00008000, 32'sh0,
      1, -32'sh1, 32'sh00008000, 32'sh0, 0, 0},
    '{PRE_W_ZERO, FUNC_POINT, 32'sh00010000, 32'sh00020000, 32'sh00030000,
      1, SAT_POS, SAT_POS, SAT_POS, 1, 0},
    '{PRE_NONE, FUNC_POINT, SAT_NEG, SAT_NEG, SAT_NEG, 1, SAT_POS, SAT_POS, SAT_POS, 1, 0},
    '{PRE_NONE, FUNC_VECTOR, SAT_POS, SAT_NEG, 32'sh00010000,
      1, SAT_POS, SAT_NEG, 32'sh00010000, 0, 0},
    '{PRE_ALL_MAX, FUNC_VECTOR, SAT_POS, SAT_POS, SAT_POS, 1, SAT_POS, SAT_POS, SAT_POS, 0, 1},
    '{PRE_NONE, FUNC_VECTOR, SAT_NEG, SAT_NEG, SAT_NEG, 1, SAT_NEG, SAT_NEG, SAT_NEG, 0, 1},
    '{PRE_NONE, FUNC_POINT, 32'sh00010000, 32'sh00010000, 32'sh00010000, 0, 0, 0, 0, 0, 0},
    '{PRE_NONE, FUNC_POINT, SAT_POS, -32'sh1, 32'sh0, 0, 0, 0, 0, 0, 0},
    '{PRE_NONE, FUNC_POINT, 32'sh1, 32'sh0, 32'sh0, 0, 0, 0, 0, 0, 0},
    '{PRE_ALL_MIN, FUNC_VECTOR, SAT_NEG, SAT_NEG, SAT_NEG, 1, SAT_POS, SAT_POS, SAT_POS, 0, 1},
    '{PRE_NONE, FUNC_POINT, SAT_NEG, SAT_POS, 32'sh00010000, 0, 0, 0, 0, 0, 0},
    '{PRE_NONE, FUNC_POINT, -32'sh00010000, 32'sh0, 32'sh0, 0, 0, 0, 0, 0, 0},
    '{PRE_IDENTITY, FUNC_POINT, -32'sh00000001, -32'sh00000002, 32'sh7FFF0000,
      1, -32'sh00000001, -32'sh00000002, 32'sh7FFF0000, 0, 0}
  };

  initial begin
    point_res_t want;
    int kind;
    for (int i = 0; i < NUM_REGS; i++) begin
      matrix[i] = (i == 0 || i == 5) ? ONE_LO : (i == 2 || i == 7) ? ONE_HI : '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].preset != PRE_NONE) begin
        in_valid <= 1'b0;
        load_preset(dir_table[i].preset);
      end
      want = '{dir_table[i].ex, dir_table[i].ey, dir_table[i].ez,
               dir_table[i].einf, dir_table[i].eovf};
      send_point(dir_table[i].func, dir_table[i].x, dir_table[i].y, dir_table[i].z,
                 dir_table[i].typed, want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      kind = p % 4;
      for (int i = 0; i < NUM_REGS; i++) begin
        // Kind 2 leaves row 3 as a single x term plus an offset, so w often cancels to zero.
        if (kind == 2 && i == 6) write_reg(i, {32'h0, rand_elem(1)});
        else if (kind == 2 && i == 7) write_reg(i, {rand_elem(1) & 32'hFFFF0000, 32'h0});
        else write_reg(i, {rand_elem(kind), rand_elem(kind)});
      end
      write_reg(NUM_REGS + $urandom_range(0, 7), {$urandom, $urandom});
      cfg_we <= 1'b0;
      no_gaps = (p == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 2 && n == 5) hold_req++;
        send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(), 0,
                   want);
      end
      no_gaps = 0;
    end

    in_valid <= 1'b0;
    wait_drained();
    $display("Sent %0d beats over %0d matrix settings; %0d results,",
             beats_in, NUM_PHASES + 5, beats_out);
    $display("%0d at infinity, %0d saturated.", inf_seen, ovf_seen);
    $display("Covered point and direction modes, zero w, saturation and long output stalls.");
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/hpt_pkg.sv
rtl/core/hpt_row.sv
rtl/core/hpt_div_step.sv
rtl/core/homogeneous_point_transform_unit.sv
rtl/core/hpt_checker.sv
dv/homogeneous_point_transform_unit_tb.sv
